// ----- sv/lru_block_buffer_cache_assert.svh -----
// assertion macros for the lru block buffer cache
`ifndef LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
`define LBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LBC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LBC_ASSERT(lbl, prop, msg)
`define LBC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/lbc_pkg.sv -----
// shared types and constants for the lru block buffer cache
package lbc_pkg;

  localparam int unsigned DEV_W = 8;
  localparam int unsigned BLK_W = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [0:0] {
    REQ_GET     = 1'b0,
    REQ_RELEASE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GET_WAIT,
    S_GET_DONE,
    S_REL_READ,
    S_REL_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic ptr_inc;
    logic get_done;
    logic rel_done;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
  } sts_t;

endpackage

// ----- sv/lbc_ram.sv -----
// generic single write port, single read port ram with registered read
module lbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lbc_ctrl.sv -----
// sequencing state machine for the lru block buffer cache
module lbc_ctrl import lbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic req_type_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (req_type_i == REQ_RELEASE) ? S_REL_READ : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.ptr_last) begin
          state_d = S_GET_WAIT;
        end
      end
      S_GET_WAIT: state_d = S_GET_DONE;
      S_GET_DONE: state_d = S_IDLE;
      S_REL_READ: state_d = S_REL_DONE;
      S_REL_DONE: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_SCAN: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
      end
      S_GET_WAIT: ;
      S_GET_DONE: cmd_o.get_done = 1'b1;
      S_REL_READ: cmd_o.rd_issue = 1'b1;
      S_REL_DONE: cmd_o.rel_done = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- sv/lbc_dp.sv -----
// tag, count and recency datapath for the lru block buffer cache
module lbc_dp import lbc_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              req_type_i,
  input  logic [DEV_W-1:0]  device_id_i,
  input  logic [BLK_W-1:0]  block_number_i,
  input  logic [IDX_W-1:0]  release_index_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  entry_index_o,
  output logic              was_hit_o,
  output logic              needs_fill_o,
  output logic [ST_W-1:0]   status_o
);

  localparam int unsigned IW    = $clog2(NUM_ENTRIES);
  localparam int unsigned TAG_W = DEV_W + BLK_W;

  logic                  req_rel_q;
  logic [DEV_W-1:0]      dev_q;
  logic [BLK_W-1:0]      blk_q;
  logic [IDX_W-1:0]      rel_idx_q;
  logic                  in_range_q;
  logic [IW-1:0]         ptr_q;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_idx_q;
  logic [NUM_ENTRIES-1:0] valid_q;
  logic [IW-1:0]         rank_q [NUM_ENTRIES];
  logic                  hit_q;
  logic [IW-1:0]         hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic                  vic_q;
  logic [IW-1:0]         vic_idx_q;
  logic [IW-1:0]         vic_rank_q;
  logic                  done_q;
  logic [IDX_W-1:0]      entry_index_q, entry_index_d;
  logic                  was_hit_q, was_hit_d;
  logic                  needs_fill_q, needs_fill_d;
  logic [ST_W-1:0]       status_q, status_d;

  logic [TAG_W-1:0]      tag_rdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [COUNT_BITS-1:0] scan_cnt;
  logic                  tag_match;
  logic [IW-1:0]         cur_rank;
  logic                  eval;
  logic                  hit_take;
  logic                  vic_take;
  logic                  cnt_max;
  logic                  tag_we;
  logic                  cnt_we;
  logic [IW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  rel_ok;
  logic                  rel_to_zero;
  logic [IW+IDX_W-1:0]   rel_ext;
  logic [IW+IDX_W-1:0]   hit_ext;
  logic [IW+IDX_W-1:0]   vic_ext;

  lbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_ENTRIES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (vic_idx_q),
    .wdata_i ({dev_q, blk_q}),
    .raddr_i (ptr_q),
    .rdata_o (tag_rdata)
  );

  lbc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_ENTRIES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (ptr_q),
    .rdata_o (cnt_rdata)
  );

  // entries never taken read as count zero
  assign scan_cnt  = valid_q[rd_idx_q] ? cnt_rdata : '0;
  assign tag_match = valid_q[rd_idx_q] && (tag_rdata == {dev_q, blk_q});
  assign cur_rank  = rank_q[rd_idx_q];
  assign eval      = rd_vld_q && !req_rel_q;
  assign hit_take  = eval && tag_match && !hit_q;
  assign vic_take  = eval && (scan_cnt == '0) && (!vic_q || (cur_rank > vic_rank_q));

  assign cnt_max     = (hit_cnt_q == {COUNT_BITS{1'b1}});
  assign rel_ok      = in_range_q && (scan_cnt != '0);
  assign rel_to_zero = cmd_i.rel_done && in_range_q && (scan_cnt == COUNT_BITS'(1));
  assign tag_we      = cmd_i.get_done && !hit_q && vic_q;

  assign rel_ext = {{IW{1'b0}}, release_index_i};
  assign hit_ext = {{IDX_W{1'b0}}, hit_idx_q};
  assign vic_ext = {{IDX_W{1'b0}}, vic_idx_q};

  assign sts_o.ptr_last = (ptr_q == IW'(NUM_ENTRIES - 1));

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = hit_idx_q;
    cnt_wdata = hit_cnt_q + COUNT_BITS'(1);
    if (cmd_i.get_done) begin
      if (hit_q) begin
        cnt_we = !cnt_max;
      end else if (vic_q) begin
        cnt_we    = 1'b1;
        cnt_waddr = vic_idx_q;
        cnt_wdata = COUNT_BITS'(1);
      end
    end else if (cmd_i.rel_done && rel_ok) begin
      cnt_we    = 1'b1;
      cnt_waddr = rd_idx_q;
      cnt_wdata = scan_cnt - COUNT_BITS'(1);
    end
  end

  always_comb begin
    entry_index_d = rel_idx_q;
    was_hit_d     = 1'b0;
    needs_fill_d  = 1'b0;
    status_d      = rel_ok ? ST_OK : ST_UNDERFLOW;
    if (cmd_i.get_done) begin
      if (hit_q) begin
        entry_index_d = hit_ext[IDX_W-1:0];
        was_hit_d     = 1'b1;
        status_d      = cnt_max ? ST_OVERFLOW : ST_OK;
      end else if (vic_q) begin
        entry_index_d = vic_ext[IDX_W-1:0];
        needs_fill_d  = 1'b1;
        status_d      = ST_OK;
      end else begin
        entry_index_d = '0;
        status_d      = ST_NO_FREE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      vic_q    <= 1'b0;
      valid_q  <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        rank_q[i] <= IW'(i);
      end
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      done_q   <= cmd_i.get_done || cmd_i.rel_done;
      if (cmd_i.load) begin
        hit_q <= 1'b0;
        vic_q <= 1'b0;
      end else begin
        if (hit_take) begin
          hit_q <= 1'b1;
        end
        if (vic_take) begin
          vic_q <= 1'b1;
        end
      end
      if (tag_we) begin
        valid_q[vic_idx_q] <= 1'b1;
      end
      // entry whose count a release drops to zero becomes most recent, newer ones age by one
      if (rel_to_zero) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (rd_idx_q == IW'(i)) begin
            rank_q[i] <= '0;
          end else if (rank_q[i] < cur_rank) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q;
    if (cmd_i.load) begin
      req_rel_q  <= req_type_i;
      dev_q      <= device_id_i;
      blk_q      <= block_number_i;
      rel_idx_q  <= release_index_i;
      in_range_q <= (32'(release_index_i) < 32'(NUM_ENTRIES));
      ptr_q      <= (req_type_i == REQ_RELEASE) ? rel_ext[IW-1:0] : '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + IW'(1);
    end
    if (hit_take) begin
      hit_idx_q <= rd_idx_q;
      hit_cnt_q <= scan_cnt;
    end
    if (vic_take) begin
      vic_idx_q  <= rd_idx_q;
      vic_rank_q <= cur_rank;
    end
    if (cmd_i.get_done || cmd_i.rel_done) begin
      entry_index_q <= entry_index_d;
      was_hit_q     <= was_hit_d;
      needs_fill_q  <= needs_fill_d;
      status_q      <= status_d;
    end
  end

  assign done_o        = done_q;
  assign entry_index_o = entry_index_q;
  assign was_hit_o     = was_hit_q;
  assign needs_fill_o  = needs_fill_q;
  assign status_o      = status_q;

endmodule

// ----- sv/lru_block_buffer_cache.sv -----
// top level of the lru block buffer cache with reference counts
//
// A request item is taken at a rising clock edge with start high and busy
// low. req_type_i selects get (device_id_i, block_number_i) or release
// (release_index_i). Each item gives exactly one result on entry_index_o,
// was_hit_o, needs_fill_o and status_o, shown for one cycle with done_o high.
// The receiver cannot stall: the result is taken at the edge that ends it.
// A get scans all NUM_ENTRIES tag and count entries, one per cycle through
// the registered read port of the tag and count memories, tracking the hit
// and the oldest free entry, then passes through S_GET_WAIT and S_GET_DONE
// before its result is registered. A release reads one entry in S_REL_READ
// and finishes in S_REL_DONE. busy is high from accept until the edge that
// raises done_o, so the next item may be accepted at the edge that takes
// the result. Reset clears the valid bits, so every count reads zero and
// nothing hits, and sets each recency rank to its entry index; the block
// is idle and accepts an item as soon as reset is released.
`include "lru_block_buffer_cache_assert.svh"

module lru_block_buffer_cache import lbc_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             req_type_i,
  input  logic [DEV_W-1:0] device_id_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  logic [IDX_W-1:0] release_index_i,
  output logic             done_o,
  output logic [IDX_W-1:0] entry_index_o,
  output logic             was_hit_o,
  output logic             needs_fill_o,
  output logic [ST_W-1:0]  status_o
);

  cmd_t cmd;
  sts_t sts;

  lbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  lbc_dp #(.NUM_ENTRIES(NUM_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .device_id_i     (device_id_i),
    .block_number_i  (block_number_i),
    .release_index_i (release_index_i),
    .done_o          (done_o),
    .entry_index_o   (entry_index_o),
    .was_hit_o       (was_hit_o),
    .needs_fill_o    (needs_fill_o),
    .status_o        (status_o)
  );

  `LBC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `LBC_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without an item in work")
  `LBC_ASSERT_NEVER(a_hit_fill, done_o && was_hit_o && needs_fill_o, "hit flagged for fill")
  `LBC_ASSERT_NEVER(a_nofree_fields,
    done_o && (status_o == ST_NO_FREE) && (was_hit_o || needs_fill_o || (entry_index_o != '0)),
    "no free entry result has stray fields")

endmodule

// ----- bench/lru_block_buffer_cache_tb.sv -----
// self-checking testbench for the lru block buffer cache
module lru_block_buffer_cache_tb import lbc_pkg::*; ();

  localparam int unsigned NUM_ENTRIES = 32;
  localparam int unsigned COUNT_BITS  = 8;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int unsigned RAND_ITEMS  = 1320;
  localparam int unsigned POOL_SIZE   = 48;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             fill;
    status_e          st;
  } outcome_t;

  typedef struct packed {
    req_e             req;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [IDX_W-1:0] idx;
    int unsigned      reps;
    int unsigned      stride;
    bit               typed;
    outcome_t         want;
  } row_t;

  localparam outcome_t NO_WANT = '{5'd0, 1'b0, 1'b0, ST_OK};
  localparam int unsigned NUM_ROWS = 19;

  localparam row_t PLAN [NUM_ROWS] = '{
    // valid bits reset to zero, so tag zero still misses
    '{REQ_GET, 8'h00, 32'h0000_0000, 5'd0, 1, 0, 1'b1, '{5'd31, 1'b0, 1'b1, ST_OK}},
    '{REQ_GET, 8'h00, 32'h0000_0000, 5'd0, 1, 0, 1'b1, '{5'd31, 1'b1, 1'b0, ST_OK}},
    '{REQ_GET, 8'hff, 32'hffff_ffff, 5'd0, 1, 0, 1'b1, '{5'd30, 1'b0, 1'b1, ST_OK}},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd31, 1, 0, 1'b1, '{5'd31, 1'b0, 1'b0, ST_OK}},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd31, 1, 0, 1'b1, '{5'd31, 1'b0, 1'b0, ST_OK}},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd31, 1, 0, 1'b1, '{5'd31, 1'b0, 1'b0, ST_UNDERFLOW}},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd0, 1, 0, 1'b1, '{5'd0, 1'b0, 1'b0, ST_UNDERFLOW}},
    // zero count but still valid: a hit
    '{REQ_GET, 8'h00, 32'h0000_0000, 5'd0, 1, 0, 1'b1, '{5'd31, 1'b1, 1'b0, ST_OK}},
    '{REQ_GET, 8'h00, 32'h0000_0000, 5'd0, COUNT_MAX - 1, 0, 1'b0, NO_WANT},
    '{REQ_GET, 8'h00, 32'h0000_0000, 5'd0, 1, 0, 1'b1, '{5'd31, 1'b1, 1'b0, ST_OVERFLOW}},
    '{REQ_GET, 8'h01, 32'h0000_0100, 5'd0, NUM_ENTRIES - 2, 1, 1'b0, NO_WANT},
    '{REQ_GET, 8'h01, 32'hdead_0000, 5'd0, 1, 0, 1'b1, '{5'd0, 1'b0, 1'b0, ST_NO_FREE}},
    '{REQ_GET, 8'hff, 32'hffff_ffff, 5'd0, 1, 0, 1'b1, '{5'd30, 1'b1, 1'b0, ST_OK}},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd0, NUM_ENTRIES, 1, 1'b0, NO_WANT},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd31, COUNT_MAX - 1, 0, 1'b0, NO_WANT},
    '{REQ_RELEASE, 8'h00, 32'h0, 5'd30, 1, 0, 1'b0, NO_WANT},
    '{REQ_GET, 8'h00, 32'hffff_ffff, 5'd0, 1, 0, 1'b0, NO_WANT},
    '{REQ_GET, 8'hff, 32'h0000_0000, 5'd0, 1, 0, 1'b0, NO_WANT},
    '{REQ_GET, 8'h5a, 32'ha5a5_a5a5, 5'd0, 1, 0, 1'b0, NO_WANT}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             req_type_i;
  logic [DEV_W-1:0] device_id_i;
  logic [BLK_W-1:0] block_number_i;
  logic [IDX_W-1:0] release_index_i;
  logic             done_o;
  logic [IDX_W-1:0] entry_index_o;
  logic             was_hit_o;
  logic             needs_fill_o;
  logic [ST_W-1:0]  status_o;

  logic [DEV_W-1:0] tag_dev [NUM_ENTRIES];
  logic [BLK_W-1:0] tag_blk [NUM_ENTRIES];
  bit               tag_valid [NUM_ENTRIES];
  int unsigned      use_count [NUM_ENTRIES];
  int unsigned      age_rank [NUM_ENTRIES];

  outcome_t    pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 38;
  int unsigned get_count = 0;
  int unsigned hit_count = 0;
  int unsigned fill_count = 0;
  int unsigned release_count = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  lru_block_buffer_cache #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .device_id_i    (device_id_i),
    .block_number_i (block_number_i),
    .release_index_i(release_index_i),
    .done_o         (done_o),
    .entry_index_o  (entry_index_o),
    .was_hit_o      (was_hit_o),
    .needs_fill_o   (needs_fill_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic outcome_t cache_get(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
    int unsigned pick;
    bit          found;
    pick  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
      if (tag_valid[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
        if (use_count[i] >= COUNT_MAX) return '{IDX_W'(i), 1'b1, 1'b0, ST_OVERFLOW};
        use_count[i]++;
        return '{IDX_W'(i), 1'b1, 1'b0, ST_OK};
      end
    end
    for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
      if (use_count[i] == 0 && (!found || age_rank[i] > age_rank[pick])) begin
        pick  = i;
        found = 1'b1;
      end
    end
    if (!found) return '{IDX_W'(0), 1'b0, 1'b0, ST_NO_FREE};
    tag_dev[pick]   = dev;
    tag_blk[pick]   = blk;
    tag_valid[pick] = 1'b1;
    use_count[pick] = 1;
    return '{IDX_W'(pick), 1'b0, 1'b1, ST_OK};
  endfunction

  function automatic outcome_t cache_release(logic [IDX_W-1:0] idx);
    int unsigned r;
    if (idx >= NUM_ENTRIES || use_count[idx] == 0) return '{idx, 1'b0, 1'b0, ST_UNDERFLOW};
    use_count[idx]--;
    if (use_count[idx] == 0) begin
      r = age_rank[idx];
      for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
        if (age_rank[i] < r) age_rank[i]++;
      end
      age_rank[idx] = 0;
    end
    return '{idx, 1'b0, 1'b0, ST_OK};
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_request(req_e req, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                              logic [IDX_W-1:0] idx, bit typed, outcome_t want);
    outcome_t got;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= req;
    device_id_i     <= dev;
    block_number_i  <= blk;
    release_index_i <= idx;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (req == REQ_GET) begin
      got = cache_get(dev, blk);
      get_count++;
      hit_count  += got.hit;
      fill_count += got.fill;
    end else begin
      got = cache_release(idx);
      release_count++;
    end
    status_seen[got.st]++;
    pending_results.push_back(typed ? want : got);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (entry_index_o !== want.idx)
          flag_mismatch($sformatf("entry_index %0d, want %0d", entry_index_o, want.idx));
        if (was_hit_o !== want.hit)
          flag_mismatch($sformatf("was_hit %b, want %b", was_hit_o, want.hit));
        if (needs_fill_o !== want.fill)
          flag_mismatch($sformatf("needs_fill %b, want %b", needs_fill_o, want.fill));
        if (status_o !== want.st)
          flag_mismatch($sformatf("status %0d, want %0d", status_o, want.st));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [DEV_W-1:0] pool_dev [POOL_SIZE];
    logic [BLK_W-1:0] pool_blk [POOL_SIZE];
    int unsigned      held [$];
    int unsigned      slot;
    logic [IDX_W-1:0] rel_idx;

    for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
      tag_dev[i]   = '0;
      tag_blk[i]   = '0;
      tag_valid[i] = 1'b0;
      use_count[i] = 0;
      age_rank[i]  = i;
    end
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    req_type_i      <= REQ_GET;
    device_id_i     <= '0;
    block_number_i  <= '0;
    release_index_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      for (int unsigned k = 0; k < PLAN[r].reps; k++) begin
        send_request(PLAN[r].req, PLAN[r].dev, PLAN[r].blk + k * PLAN[r].stride,
                     PLAN[r].idx + IDX_W'(k * PLAN[r].stride), PLAN[r].typed, PLAN[r].want);
      end
    end

    for (int unsigned i = 0; i < POOL_SIZE; i++) begin
      pool_dev[i] = DEV_W'($urandom_range(255));
      pool_blk[i] = $urandom();
    end

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      idle_pct = (n >= 600 && n < 900) ? 0 : 38;
      if (n % 300 == 150) begin
        while (pending_results.size() != 0) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
      end
      if ($urandom_range(99) < 50) begin
        if ($urandom_range(99) < 65) begin
          slot = $urandom_range(POOL_SIZE - 1);
          send_request(REQ_GET, pool_dev[slot], pool_blk[slot], IDX_W'($urandom_range(31)),
                       1'b0, NO_WANT);
        end else begin
          send_request(REQ_GET, DEV_W'($urandom_range(255)), $urandom(),
                       IDX_W'($urandom_range(31)), 1'b0, NO_WANT);
        end
      end else begin
        held.delete();
        for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
          if (use_count[i] != 0) held.push_back(i);
        end
        if (held.size() != 0 && $urandom_range(99) < 85)
          rel_idx = IDX_W'(held[$urandom_range(held.size() - 1)]);
        else
          rel_idx = IDX_W'($urandom_range(31));
        send_request(REQ_RELEASE, DEV_W'($urandom_range(255)), $urandom(), rel_idx,
                     1'b0, NO_WANT);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NUM_ENTRIES + 8) @(posedge clk_i);

    $display("covered %0d gets (%0d hits, %0d fills) and %0d releases",
             get_count, hit_count, fill_count, release_count);
    $display("status seen: ok %0d, no free %0d, underflow %0d, overflow %0d",
             status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_UNDERFLOW],
             status_seen[ST_OVERFLOW]);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/lbc_pkg.sv
sv/lbc_ram.sv
sv/lbc_ctrl.sv
sv/lbc_dp.sv
sv/lru_block_buffer_cache.sv
bench/lru_block_buffer_cache_tb.sv
